/* hdl/ufst_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufst_pkg - shared types and constants for the UDP flow signature tracker
// Field widths, filter constants, sequencer states and the bucket hash.
// ----------------------------------------------------------------------------
package ufst_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 128;
  localparam int unsigned HASH_BUCKETS_DEF  = 4096;

  localparam int unsigned IP_W    = 32;
  localparam int unsigned PORT_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KEY_W   = IP_W + PORT_W;
  localparam int unsigned HASH_W  = 16;

  localparam logic [BYTE_W-1:0] SIG_MARK   = 8'h02;
  localparam logic [PORT_W-1:0] DNS_PORT   = 16'd53;
  localparam logic [BYTE_W-1:0] COUNT_MAX  = 8'hFF;
  localparam logic [BYTE_W-1:0] THR_RESET  = 8'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_HEAD,
    ST_WALK,
    ST_HIT,
    ST_EV_KEY,
    ST_EV_HEAD,
    ST_EV_WALK,
    ST_REHEAD,
    ST_INSERT
  } ufst_state_e;

  // per-direction record of one flow
  typedef struct packed {
    logic [BYTE_W-1:0] ident;
    logic [BYTE_W-1:0] count;
  } ufst_dir_t;

  // folded XOR of the key: ip[31:16] ^ ip[15:0] ^ port
  function automatic logic [HASH_W-1:0] fold_hash(input logic [KEY_W-1:0] key);
    return key[47:32] ^ key[31:16] ^ key[15:0];
  endfunction

  // packet qualifies for table tracking
  function automatic logic is_candidate(input logic              ok,
                                        input logic [PORT_W-1:0] dport,
                                        input logic [BYTE_W-1:0] b2);
    return ok && (dport != DNS_PORT) && (b2 == SIG_MARK);
  endfunction

endpackage

/* hdl/ufst_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufst_if - valid/ready channels of the UDP flow signature tracker
// Packet event input, verdict output and threshold configuration write.
// ----------------------------------------------------------------------------
interface ufst_in_if;
  logic                         valid;
  logic                         ready;
  logic [ufst_pkg::IP_W-1:0]    flow_ip;
  logic [ufst_pkg::PORT_W-1:0]  flow_port;
  logic                         direction;
  logic [ufst_pkg::PORT_W-1:0]  packet_dst_port;
  logic [ufst_pkg::BYTE_W-1:0]  first_byte;
  logic [ufst_pkg::BYTE_W-1:0]  third_byte;
  logic                         prefilter_ok;

  modport source (output valid, flow_ip, flow_port, direction, packet_dst_port,
                  first_byte, third_byte, prefilter_ok, input ready);
  modport sink   (input valid, flow_ip, flow_port, direction, packet_dst_port,
                  first_byte, third_byte, prefilter_ok, output ready);
endinterface

interface ufst_out_if;
  logic valid;
  logic ready;
  logic verdict;

  modport source (output valid, verdict, input ready);
  modport sink   (input valid, verdict, output ready);
endinterface

interface ufst_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ufst_pkg::BYTE_W-1:0]  repeat_threshold;

  modport source (output valid, repeat_threshold, input ready);
  modport sink   (input valid, repeat_threshold, output ready);
endinterface

/* hdl/udp_flow_signature_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udp_flow_signature_tracker - per-flow payload signature detector
// Hashed flow table with chained buckets, FIFO eviction, one verdict per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one packet event per item (flow key, direction, ports, payload
//           bytes, prefilter flag). Ready only while the sequencer is idle.
//   out_o : exactly one verdict item per input item, in order, held in an
//           output register until taken; a stalled receiver blocks the next
//           input item only (the block never drops or repeats a verdict).
//   cfg_i : writes repeat_threshold; always ready, write only while idle.
// Sequence per item (one item at a time):
//   rejected item        : verdict the cycle after acceptance
//   hit at chain depth k : bucket head read, k key reads, then
//                          one entry data read-modify-write
//   miss, table not full : chain walk, then head re-read and insert
//   miss with eviction   : adds an unlink of the evicted entry: its key and
//                          bucket head reads, then a walk of its own chain
//   Each table memory has a single read port, so these reads are sequential.
// Reset: the bucket head memory is cleared one entry per cycle, all
//   HASH_BUCKETS entries; no input item is accepted meanwhile.
// HASH_BUCKETS must be a power of two (bucket index is the low hash bits).
// ----------------------------------------------------------------------------
module udp_flow_signature_tracker #(
  parameter int unsigned TABLE_ENTRIES = ufst_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned HASH_BUCKETS  = ufst_pkg::HASH_BUCKETS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufst_in_if.sink     in_i,
  ufst_out_if.source  out_o,
  ufst_cfg_if.sink    cfg_i
);

  localparam int unsigned SLOT_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned PTR_W  = $clog2(TABLE_ENTRIES + 1);  // slot + 1, 0 = none
  localparam int unsigned BKT_W  = $clog2(HASH_BUCKETS);
  localparam int unsigned KEY_W  = ufst_pkg::KEY_W;
  localparam int unsigned BYTE_W = ufst_pkg::BYTE_W;

  typedef ufst_pkg::ufst_dir_t [1:0] entry_data_t;

  function automatic logic [SLOT_W-1:0] ptr2slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] t;
    t = p - PTR_W'(1);
    return t[SLOT_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] slot2ptr(input logic [SLOT_W-1:0] s);
    return PTR_W'(s) + PTR_W'(1);
  endfunction

  // --------------------------------------------------------------------------
  // Table memories: one write and one registered read port each
  // --------------------------------------------------------------------------
  logic [PTR_W-1:0]  head_mem [HASH_BUCKETS];   // bucket -> first entry
  logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
  logic [PTR_W-1:0]  link_mem [TABLE_ENTRIES];  // next entry in bucket
  entry_data_t       data_mem [TABLE_ENTRIES];  // ident/count per direction

  logic              head_we, head_re;
  logic [BKT_W-1:0]  head_waddr, head_raddr;
  logic [PTR_W-1:0]  head_wdata, head_rd_q;

  logic              key_we, key_re;
  logic [SLOT_W-1:0] key_waddr, key_raddr;
  logic [KEY_W-1:0]  key_rd_q;
  logic [KEY_W-1:0]  key_q, key_d;          // item key, also the key write data

  logic              link_we, link_re;
  logic [SLOT_W-1:0] link_waddr, link_raddr;
  logic [PTR_W-1:0]  link_wdata, link_rd_q;

  logic              data_we, data_re;
  logic [SLOT_W-1:0] data_waddr, data_raddr;
  entry_data_t       data_wdata, data_rd_q;

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd_q <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_q;
    end
    if (key_re) begin
      key_rd_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_q <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (data_re) begin
      data_rd_q <= data_mem[data_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer state and item registers
  // --------------------------------------------------------------------------
  ufst_pkg::ufst_state_e state_q, state_d;

  logic [BKT_W-1:0]  clr_q, clr_d;
  logic              dir_q, dir_d;
  logic [BYTE_W-1:0] b0_q, b0_d;
  logic [SLOT_W-1:0] slot_q, slot_d;       // slot under test / being filled
  logic [PTR_W-1:0]  prev_q, prev_d;       // predecessor during unlink
  logic [PTR_W-1:0]  ev_link_q, ev_link_d; // successor of evicted entry
  logic [BKT_W-1:0]  ev_bkt_q, ev_bkt_d;   // bucket of evicted entry
  logic [PTR_W-1:0]  fill_q, fill_d;       // slots in use, always a prefix
  logic [SLOT_W-1:0] oldest_q, oldest_d;
  logic [BYTE_W-1:0] thr_q;
  logic              out_valid_q, out_valid_d;
  logic              out_verdict_q, out_verdict_d;

  // shared hash unit: new key, or key of the entry being evicted
  logic [KEY_W-1:0]            hash_key;
  logic [ufst_pkg::HASH_W-1:0] hash_full;
  logic [BKT_W-1:0]            bkt;
  logic                        key_hit;

  assign hash_key  = (state_q == ufst_pkg::ST_EV_KEY) ? key_rd_q : key_q;
  assign hash_full = ufst_pkg::fold_hash(hash_key);
  assign bkt       = hash_full[BKT_W-1:0];
  assign key_hit   = (key_rd_q == key_q);

  logic              in_ready;
  logic              go_miss;
  ufst_pkg::ufst_dir_t me_rec, other_rec;
  logic [BYTE_W-1:0] new_count;

  assign me_rec    = data_rd_q[dir_q];
  assign other_rec = data_rd_q[~dir_q];

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    key_d         = key_q;
    dir_d         = dir_q;
    b0_d          = b0_q;
    slot_d        = slot_q;
    prev_d        = prev_q;
    ev_link_d     = ev_link_q;
    ev_bkt_d      = ev_bkt_q;
    fill_d        = fill_q;
    oldest_d      = oldest_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_verdict_d = out_verdict_q;
    in_ready      = 1'b0;
    go_miss       = 1'b0;
    new_count     = me_rec.count;

    head_we    = 1'b0;
    head_waddr = bkt;
    head_wdata = '0;
    head_re    = 1'b0;
    head_raddr = bkt;
    key_we     = 1'b0;
    key_waddr  = slot_q;
    key_re     = 1'b0;
    key_raddr  = slot_q;
    link_we    = 1'b0;
    link_waddr = slot_q;
    link_wdata = head_rd_q;
    link_re    = 1'b0;
    link_raddr = slot_q;
    data_we    = 1'b0;
    data_waddr = slot_q;
    data_wdata = data_rd_q;
    data_re    = 1'b0;
    data_raddr = slot_q;

    case (state_q)
      ufst_pkg::ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
        head_wdata = '0;
        clr_d      = clr_q + BKT_W'(1);
        if (clr_q == BKT_W'(HASH_BUCKETS - 1)) begin
          state_d = ufst_pkg::ST_IDLE;
        end
      end

      ufst_pkg::ST_IDLE: begin
        in_ready = !out_valid_q || out_o.ready;
        if (in_i.valid && in_ready) begin
          key_d = {in_i.flow_ip, in_i.flow_port};
          dir_d = in_i.direction;
          b0_d  = in_i.first_byte;
          if (ufst_pkg::is_candidate(in_i.prefilter_ok, in_i.packet_dst_port,
                                     in_i.third_byte)) begin
            state_d = ufst_pkg::ST_LOOKUP;
          end else begin
            out_valid_d   = 1'b1;
            out_verdict_d = 1'b0;
          end
        end
      end

      ufst_pkg::ST_LOOKUP: begin
        head_re    = 1'b1;
        head_raddr = bkt;
        state_d    = ufst_pkg::ST_HEAD;
      end

      ufst_pkg::ST_HEAD: begin
        if (head_rd_q == '0) begin
          go_miss = 1'b1;
        end else begin
          slot_d    = ptr2slot(head_rd_q);
          key_re    = 1'b1;
          key_raddr = ptr2slot(head_rd_q);
          link_re   = 1'b1;
          link_raddr = ptr2slot(head_rd_q);
          state_d   = ufst_pkg::ST_WALK;
        end
      end

      ufst_pkg::ST_WALK: begin
        if (key_hit) begin
          data_re    = 1'b1;
          data_raddr = slot_q;
          state_d    = ufst_pkg::ST_HIT;
        end else if (link_rd_q == '0) begin
          go_miss = 1'b1;
        end else begin
          slot_d     = ptr2slot(link_rd_q);
          key_re     = 1'b1;
          key_raddr  = ptr2slot(link_rd_q);
          link_re    = 1'b1;
          link_raddr = ptr2slot(link_rd_q);
        end
      end

      ufst_pkg::ST_HIT: begin
        out_valid_d   = 1'b1;
        out_verdict_d = 1'b0;
        state_d       = ufst_pkg::ST_IDLE;
        data_waddr    = slot_q;
        data_wdata    = data_rd_q;
        if (me_rec.count == '0) begin
          // first byte seen for this direction
          new_count                  = BYTE_W'(1);
          data_wdata[dir_q].ident    = b0_q;
          data_wdata[dir_q].count    = new_count;
          data_we                    = 1'b1;
          out_verdict_d = (new_count >= thr_q) && (other_rec.count >= thr_q);
        end else if (me_rec.ident == b0_q) begin
          if (me_rec.count != ufst_pkg::COUNT_MAX) begin
            new_count = me_rec.count + BYTE_W'(1);
          end
          data_wdata[dir_q].count = new_count;
          data_we                 = 1'b1;
          out_verdict_d = (new_count >= thr_q) && (other_rec.count >= thr_q);
        end
      end

      ufst_pkg::ST_EV_KEY: begin
        // key_rd_q / link_rd_q hold the evicted entry
        ev_link_d  = link_rd_q;
        ev_bkt_d   = bkt;
        head_re    = 1'b1;
        head_raddr = bkt;
        state_d    = ufst_pkg::ST_EV_HEAD;
      end

      ufst_pkg::ST_EV_HEAD: begin
        if (head_rd_q == slot2ptr(slot_q)) begin
          head_we    = 1'b1;
          head_waddr = ev_bkt_q;
          head_wdata = ev_link_q;
          state_d    = ufst_pkg::ST_REHEAD;
        end else if (head_rd_q == '0) begin
          state_d = ufst_pkg::ST_REHEAD;
        end else begin
          prev_d     = head_rd_q;
          link_re    = 1'b1;
          link_raddr = ptr2slot(head_rd_q);
          state_d    = ufst_pkg::ST_EV_WALK;
        end
      end

      ufst_pkg::ST_EV_WALK: begin
        if (link_rd_q == slot2ptr(slot_q)) begin
          link_we    = 1'b1;
          link_waddr = ptr2slot(prev_q);
          link_wdata = ev_link_q;
          state_d    = ufst_pkg::ST_REHEAD;
        end else if (link_rd_q == '0) begin
          state_d = ufst_pkg::ST_REHEAD;
        end else begin
          prev_d     = link_rd_q;
          link_re    = 1'b1;
          link_raddr = ptr2slot(link_rd_q);
        end
      end

      ufst_pkg::ST_REHEAD: begin
        // head may have changed during unlink
        head_re    = 1'b1;
        head_raddr = bkt;
        state_d    = ufst_pkg::ST_INSERT;
      end

      ufst_pkg::ST_INSERT: begin
        key_we     = 1'b1;
        key_waddr  = slot_q;
        link_we    = 1'b1;
        link_waddr = slot_q;
        link_wdata = head_rd_q;
        head_we    = 1'b1;
        head_waddr = bkt;
        head_wdata = slot2ptr(slot_q);
        data_we    = 1'b1;
        data_waddr = slot_q;
        data_wdata = '0;
        data_wdata[dir_q].ident = b0_q;
        data_wdata[dir_q].count = BYTE_W'(1);
        out_valid_d   = 1'b1;
        out_verdict_d = 1'b0;
        state_d       = ufst_pkg::ST_IDLE;
      end

      default: begin
        state_d = ufst_pkg::ST_IDLE;
      end
    endcase

    // lookup miss: take next free slot, or evict the oldest
    if (go_miss) begin
      if (fill_q != PTR_W'(TABLE_ENTRIES)) begin
        slot_d  = fill_q[SLOT_W-1:0];
        fill_d  = fill_q + PTR_W'(1);
        state_d = ufst_pkg::ST_REHEAD;
      end else begin
        slot_d     = oldest_q;
        key_re     = 1'b1;
        key_raddr  = oldest_q;
        link_re    = 1'b1;
        link_raddr = oldest_q;
        oldest_d   = (oldest_q == SLOT_W'(TABLE_ENTRIES - 1)) ? '0
                                                              : oldest_q + SLOT_W'(1);
        state_d    = ufst_pkg::ST_EV_KEY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ufst_pkg::ST_CLEAR;
      clr_q       <= '0;
      fill_q      <= '0;
      oldest_q    <= '0;
      thr_q       <= ufst_pkg::THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        thr_q <= cfg_i.repeat_threshold;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q         <= key_d;
    dir_q         <= dir_d;
    b0_q          <= b0_d;
    slot_q        <= slot_d;
    prev_q        <= prev_d;
    ev_link_q     <= ev_link_d;
    ev_bkt_q      <= ev_bkt_d;
    out_verdict_q <= out_verdict_d;
  end

  assign in_i.ready    = in_ready;
  assign cfg_i.ready   = 1'b1;
  assign out_o.valid   = out_valid_q;
  assign out_o.verdict = out_verdict_q;

endmodule

/* hdl/ufst_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufst_checker - port-level assertions for the UDP flow signature tracker
// Bound to the top level; watches the item channels only.
// ----------------------------------------------------------------------------
module ufst_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [ufst_pkg::PORT_W-1:0]  in_dport_i,
  input  logic [ufst_pkg::BYTE_W-1:0]  in_b2_i,
  input  logic                         in_ok_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         out_verdict_i
);

  logic in_acc;
  logic cand;

  assign in_acc = in_valid_i && in_ready_i;
  assign cand   = ufst_pkg::is_candidate(in_ok_i, in_dport_i, in_b2_i);

  // a waiting verdict holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_verdict_i))
    else $error("verdict changed or dropped while stalled");

  // no item taken while an untaken verdict would be overwritten
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !out_valid_i || out_ready_i)
    else $error("item accepted over a pending verdict");

  // filtered-out item answers unknown in the next cycle
  a_reject_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !cand |=> out_valid_i && !out_verdict_i)
    else $error("rejected item did not give an immediate unknown verdict");

  // a tracked item occupies the sequencer
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cand |=> !in_ready_i)
    else $error("ready while a table lookup is in progress");

endmodule

bind udp_flow_signature_tracker ufst_checker u_ufst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_dport_i    (in_i.packet_dst_port),
  .in_b2_i       (in_i.third_byte),
  .in_ok_i       (in_i.prefilter_ok),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_verdict_i (out_o.verdict)
);
